// ===== rtl/core/usmg_pkg.sv =====
// Shared types and constants of the UV sphere mesh generator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package usmg_pkg;

    // Field widths
    localparam int CNT_W  = 9;
    localparam int IDX_W  = 17;
    localparam int Q14_W  = 16;
    localparam int HALF_W = 8;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT  = 1'b1;
    localparam logic [CNT_W-1:0] SECTOR_RESET = 9'd32;
    localparam logic [CNT_W-1:0] STACK_RESET  = 9'd16;
    localparam logic [CNT_W-1:0] SECTOR_MIN   = 9'd3;
    localparam logic [CNT_W-1:0] STACK_MIN    = 9'd2;

    // Item function codes
    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_CELL   = 1'b1;

    // Divider chain: one quotient bit per cell, four lanes side by side
    localparam int DIV_STEPS  = 32;
    localparam int DIV_LANES  = 4;
    localparam int LANE_PH_SE = 0;
    localparam int LANE_PH_ST = 1;
    localparam int LANE_TEX_S = 2;
    localparam int LANE_TEX_T = 3;
    localparam int LANE_BITS [DIV_LANES] = '{32, 31, 15, 15};

    // Fixed-point trigonometry
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int SC_LAT = 17;

    typedef struct packed {
        logic             func;
        logic [CNT_W-1:0] stack_index;
        logic [CNT_W-1:0] sector_index;
    } t_in_item;

    typedef struct packed {
        logic signed [Q14_W-1:0] pos_x;
        logic signed [Q14_W-1:0] pos_y;
        logic signed [Q14_W-1:0] pos_z;
        logic signed [Q14_W-1:0] norm_x;
        logic signed [Q14_W-1:0] norm_y;
        logic signed [Q14_W-1:0] norm_z;
        logic [Q14_W-1:0]        tex_s;
        logic [Q14_W-1:0]        tex_t;
        logic [IDX_W-1:0]        tri_first;
        logic [IDX_W-1:0]        tri_second;
        logic [IDX_W-1:0]        tri_third;
        logic                    last_of_run;
    } t_out_item;

    // Side data that rides along the divider chain
    typedef struct packed {
        logic             func;
        logic             i_eq_nt;
        logic             j_eq_ns;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
        logic             has_up;
        logic             has_dn;
    } t_meta;

    typedef struct packed {
        logic [DIV_LANES-1:0][CNT_W-1:0] rem;
        logic [DIV_LANES-1:0][31:0]      quo;
        t_meta                           meta;
    } t_div_state;

    // Side data that rides along the trigonometry stages
    typedef struct packed {
        logic             func;
        logic [Q14_W-1:0] tex_s;
        logic [Q14_W-1:0] tex_t;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
        logic             has_up;
        logic             has_dn;
    } t_post;

endpackage

// ===== rtl/core/usmg_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit for each of the four lanes that is active.
// Depends on usmg_pkg.
`timescale 1ns / 1ps

module usmg_div_cell #(
    parameter int POS = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [8:0]            i_ns,
    input  logic [8:0]            i_nt,
    input  logic                  i_vld,
    input  usmg_pkg::t_div_state  i_state,
    output logic                  o_vld,
    output usmg_pkg::t_div_state  o_state
);
    import usmg_pkg::*;

    // Numerator bit brought down by this cell
    localparam int BIT = DIV_STEPS - 1 - POS;

    logic                            r_vld;
    t_div_state                      r_state;
    logic                            w_nb_s;
    logic                            w_nb_t;
    logic [DIV_LANES-1:0][CNT_W-1:0] w_rem_n;
    logic [DIV_LANES-1:0][31:0]      w_quo_n;

    // The rounding offset is half the divisor, so its bits are the divisor's shifted by one.
    if (BIT < HALF_W) begin : g_low
        assign w_nb_s = i_ns[BIT+1];
        assign w_nb_t = i_nt[BIT+1];
    end else begin : g_high
        assign w_nb_s = 1'b0;
        assign w_nb_t = 1'b0;
    end

    // Compare and subtract in every lane that has begun its quotient.
    for (genvar k = 0; k < DIV_LANES; k++) begin : g_lane
        localparam bit ACTIVE = (POS >= (DIV_STEPS - LANE_BITS[k]));
        localparam bit BY_NS  = (k == LANE_PH_SE) || (k == LANE_TEX_S);
        if (ACTIVE) begin : g_act
            logic [CNT_W-1:0] w_d;
            logic [CNT_W:0]   w_sh;
            logic             w_ge;
            assign w_d  = BY_NS ? i_ns : i_nt;
            assign w_sh = {i_state.rem[k], (BY_NS ? w_nb_s : w_nb_t)};
            assign w_ge = (w_sh >= {1'b0, w_d});
            assign w_rem_n[k] = w_ge ? CNT_W'(w_sh - {1'b0, w_d}) : w_sh[CNT_W-1:0];
            assign w_quo_n[k] = {i_state.quo[k][30:0], w_ge};
        end else begin : g_idle
            assign w_rem_n[k] = i_state.rem[k];
            assign w_quo_n[k] = i_state.quo[k];
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Partial remainders and quotients
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state.rem  <= w_rem_n;
            r_state.quo  <= w_quo_n;
            r_state.meta <= i_state.meta;
        end
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;

endmodule

// ===== rtl/core/usmg_poly_cell.sv =====
// One Horner step of a truncating Taylor polynomial in Q30: t' = ((a*t)>>30)/DIV,
// subtracted from 1 when SUB is set. Three register stages. Depends on usmg_pkg.
`timescale 1ns / 1ps

module usmg_poly_cell #(
    parameter int DIV = 6,
    parameter bit SUB = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_a,
    input  logic [30:0] i_t,
    output logic [30:0] o_t
);
    import usmg_pkg::*;

    localparam int          SHIFT = $clog2(DIV);
    localparam bit          POW2  = ((1 << SHIFT) == DIV);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [30:0] r_v;
    logic [30:0] r_vb;
    logic [30:0] r_qe;
    logic [30:0] r_t;
    logic [60:0] w_prod;
    logic [62:0] w_rprod;
    logic [30:0] w_qe;
    logic [36:0] w_rem;
    logic [30:0] w_q;

    // Product, back to Q30
    assign w_prod = 61'(i_a) * 61'(i_t);

    // Quotient estimate: a shift, or the reciprocal that may fall one short
    assign w_rprod = 63'(r_v) * 63'(RECIP);
    assign w_qe    = POW2 ? (r_v >> SHIFT) : 31'(w_rprod >> 32);

    // Correction of the estimate
    assign w_rem = 37'(r_vb) - 37'(r_qe) * 37'(DIV);
    assign w_q   = r_qe + 31'(w_rem >= 37'(DIV));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v  <= 31'(w_prod >> 30);
            r_vb <= r_v;
            r_qe <= w_qe;
            r_t  <= SUB ? (Q30_ONE - w_q) : w_q;
        end
    end

    assign o_t = r_t;

endmodule

// ===== rtl/core/usmg_sincos.sv =====
// Cosine and sine of a phase in 2^-32 turn units, signed Q30, in a fixed pipeline.
// Octant fold, angle scaling, a chain of Horner cells, quadrant unfold. Depends on usmg_pkg.
`timescale 1ns / 1ps

module usmg_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import usmg_pkg::*;

    localparam int X2_DL = 9;
    localparam int X_DL  = 9;
    localparam int QS_DL = 12;

    logic [29:0] w_f;
    logic        w_swap;
    logic [29:0] w_r;
    logic [2:0]  r1_qs;
    logic [2:0]  r2_qs;
    logic [2:0]  r3_qs;
    logic [2:0]  r4_qs;
    logic [60:0] r1_prod;
    logic [29:0] r2_x;
    logic [59:0] r3_x2f;
    logic [29:0] r3_x;
    logic [29:0] r4_x2;
    logic [29:0] r4_x;
    logic [29:0] r_x2_dl [X2_DL];
    logic [29:0] r_x_dl  [X_DL];
    logic [2:0]  r_qs_dl [QS_DL];
    logic [30:0] w_s0, w_s1, w_s2, w_sn;
    logic [30:0] w_c0, w_c1, w_c2, w_cs;
    logic [30:0] w_sf;
    logic [30:0] w_cf;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    // Fold the phase into the first octant of its quadrant.
    assign w_f    = i_phase[29:0];
    assign w_swap = (w_f > 30'h2000_0000);
    assign w_r    = w_swap ? 30'(31'h4000_0000 - {1'b0, w_f}) : w_f;

    // Turn units to radians, then the square of the angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= 61'(w_r) * 61'(HALF_PI_Q30);
            r1_qs   <= {i_phase[31:30], w_swap};
            r2_x    <= 30'((r1_prod + 61'h2000_0000) >> 30);
            r2_qs   <= r1_qs;
            r3_x2f  <= 60'(r2_x) * 60'(r2_x);
            r3_x    <= r2_x;
            r3_qs   <= r2_qs;
            r4_x2   <= 30'((r3_x2f + 60'h2000_0000) >> 30);
            r4_x    <= r3_x;
            r4_qs   <= r3_qs;
        end
    end

    // Delay lines that keep the angle beside the Horner cells
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2_dl[0] <= r4_x2;
            r_x_dl[0]  <= r4_x;
            r_qs_dl[0] <= r4_qs;
            for (int n = 1; n < X2_DL; n++) begin
                r_x2_dl[n] <= r_x2_dl[n-1];
            end
            for (int n = 1; n < X_DL; n++) begin
                r_x_dl[n] <= r_x_dl[n-1];
            end
            for (int n = 1; n < QS_DL; n++) begin
                r_qs_dl[n] <= r_qs_dl[n-1];
            end
        end
    end

    // Sine: x * (1 - x2/6 * (1 - x2/20 * (1 - x2/42)))
    usmg_poly_cell #(.DIV(42), .SUB(1'b1)) u_sin0 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r4_x2), .i_t(Q30_ONE), .o_t(w_s0));
    usmg_poly_cell #(.DIV(20), .SUB(1'b1)) u_sin1 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x2_dl[2]), .i_t(w_s0), .o_t(w_s1));
    usmg_poly_cell #(.DIV(6), .SUB(1'b1)) u_sin2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x2_dl[5]), .i_t(w_s1), .o_t(w_s2));
    usmg_poly_cell #(.DIV(1), .SUB(1'b0)) u_sin3 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x_dl[8]), .i_t(w_s2), .o_t(w_sn));

    // Cosine: 1 - x2/2 * (1 - x2/12 * (1 - x2/30 * (1 - x2/56)))
    usmg_poly_cell #(.DIV(56), .SUB(1'b1)) u_cos0 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r4_x2), .i_t(Q30_ONE), .o_t(w_c0));
    usmg_poly_cell #(.DIV(30), .SUB(1'b1)) u_cos1 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x2_dl[2]), .i_t(w_c0), .o_t(w_c1));
    usmg_poly_cell #(.DIV(12), .SUB(1'b1)) u_cos2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x2_dl[5]), .i_t(w_c1), .o_t(w_c2));
    usmg_poly_cell #(.DIV(2), .SUB(1'b1)) u_cos3 (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x2_dl[8]), .i_t(w_c2), .o_t(w_cs));

    // Unfold the octant, then the quadrant.
    assign w_sf = r_qs_dl[QS_DL-1][0] ? w_cs : w_sn;
    assign w_cf = r_qs_dl[QS_DL-1][0] ? w_sn : w_cs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_qs_dl[QS_DL-1][2:1])
                2'd0: begin
                    r_cos <= $signed({1'b0, w_cf});
                    r_sin <= $signed({1'b0, w_sf});
                end
                2'd1: begin
                    r_cos <= -$signed({1'b0, w_sf});
                    r_sin <= $signed({1'b0, w_cf});
                end
                2'd2: begin
                    r_cos <= -$signed({1'b0, w_cf});
                    r_sin <= -$signed({1'b0, w_sf});
                end
                default: begin
                    r_cos <= $signed({1'b0, w_sf});
                    r_sin <= -$signed({1'b0, w_cf});
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== rtl/core/uv_sphere_mesh_generator_unit.sv =====
// Top level of the UV sphere mesh generator: configuration, divider chain,
// trigonometry, product stage and output buffer. Depends on usmg_pkg and all usmg_ modules.
`timescale 1ns / 1ps
//
//  Channel   Signals                                  Direction
//  ------------------------------------------------------------------
//  config    i_cfg_we, i_cfg_idx, i_cfg_data          write only
//  input     i_in_valid, o_in_ready, i_in_item        item in
//  output    o_out_valid, i_out_ready, o_out_item     results out
//
//  From an input transfer to its first result, an item passes 32 divider
//  cells, 17 trigonometry stages, one product stage and the output buffer.
//  One item enters per cycle while results are taken; a cell item with two
//  triangles holds the output buffer for two transfers before the next enters.
//  Reset clears the valid bits and sets the counts to 32 sectors and 16 stacks.
//  While the output buffer holds a result that is not taken, the whole pipeline
//  stands still and o_in_ready is low.

module uv_sphere_mesh_generator_unit #(
    parameter int MAX_SECTORS = 256,
    parameter int MAX_STACKS  = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [usmg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [usmg_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  usmg_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output usmg_pkg::t_out_item               o_out_item
);
    import usmg_pkg::*;

    localparam int POST_LAT = SC_LAT + 1;

    logic [CNT_W-1:0] r_sector_count;
    logic [CNT_W-1:0] r_stack_count;
    logic [CNT_W-1:0] w_ns;
    logic [CNT_W-1:0] w_nt;
    logic             w_en;

    logic [CNT_W-1:0] w_iv, w_jv, w_ic, w_jc;
    logic [19:0]      w_k1;
    logic [19:0]      w_k2;
    t_div_state       w_start;
    logic             w_div_vld [DIV_STEPS+1];
    t_div_state       w_div     [DIV_STEPS+1];

    t_post            w_post_in;
    logic             r_post_vld [POST_LAT];
    t_post            r_post     [POST_LAT];
    logic [31:0]      w_ph_st;
    logic signed [31:0] w_se_cos, w_se_sin, w_st_cos, w_st_sin;

    logic [61:0]      r_m_px_mag;
    logic             r_m_px_neg;
    logic [61:0]      r_m_py_mag;
    logic             r_m_py_neg;
    logic [30:0]      r_m_z_mag;
    logic             r_m_z_neg;

    logic             r_ob_vld;
    logic             r_ob_sel;
    logic             r_ob_two;
    t_out_item        r_ob_res0;
    t_out_item        r_ob_res1;
    t_out_item        w_res0;
    t_out_item        w_res1;
    logic             w_two;
    t_out_item        w_vtx;
    t_out_item        w_tri_a;
    t_out_item        w_tri_b;

    // Magnitude of a signed Q30 value
    function automatic logic [30:0] f_mag(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m[30:0];
    endfunction

    // Divide a magnitude by 2^sh, round half away from zero, reapply the sign.
    function automatic logic [15:0] f_rnd(input logic [61:0] mag, input logic neg,
                                          input int sh);
        logic [62:0] s;
        logic [62:0] m;
        s = {1'b0, mag} + (63'd1 << (sh - 1));
        m = s >> sh;
        return neg ? 16'(-m) : m[15:0];
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= SECTOR_RESET;
            r_stack_count  <= STACK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data;
                CFG_STACK_COUNT:  r_stack_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counts in use, clamped to the legal ranges
    always_comb begin
        if (r_sector_count < SECTOR_MIN) begin
            w_ns = SECTOR_MIN;
        end else if (int'(r_sector_count) > MAX_SECTORS) begin
            w_ns = CNT_W'(MAX_SECTORS);
        end else begin
            w_ns = r_sector_count;
        end
        if (r_stack_count < STACK_MIN) begin
            w_nt = STACK_MIN;
        end else if (int'(r_stack_count) > MAX_STACKS) begin
            w_nt = CNT_W'(MAX_STACKS);
        end else begin
            w_nt = r_stack_count;
        end
    end

    // The pipeline moves whenever the output buffer is free or is being emptied.
    assign w_en       = !r_ob_vld || (i_out_ready && (!r_ob_two || r_ob_sel));
    assign o_in_ready = w_en;

    // Index clamping and triangle corners of the incoming item
    always_comb begin
        w_iv = (i_in_item.stack_index  > w_nt) ? w_nt : i_in_item.stack_index;
        w_jv = (i_in_item.sector_index > w_ns) ? w_ns : i_in_item.sector_index;
        w_ic = (i_in_item.stack_index  > w_nt - 9'd1) ? w_nt - 9'd1 : i_in_item.stack_index;
        w_jc = (i_in_item.sector_index > w_ns - 9'd1) ? w_ns - 9'd1 : i_in_item.sector_index;
        w_k1 = 20'(w_ic) * 20'({1'b0, w_ns} + 10'd1) + 20'(w_jc);
        w_k2 = w_k1 + 20'(w_ns) + 20'd1;

        w_start.rem[LANE_PH_SE] = (w_jv == w_ns) ? '0 : w_jv;
        w_start.rem[LANE_TEX_S] = (w_jv == w_ns) ? '0 : w_jv;
        w_start.rem[LANE_PH_ST] = (w_iv == w_nt) ? '0 : w_iv;
        w_start.rem[LANE_TEX_T] = (w_iv == w_nt) ? '0 : w_iv;
        w_start.quo             = '0;
        w_start.meta.func       = i_in_item.func;
        w_start.meta.i_eq_nt    = (w_iv == w_nt);
        w_start.meta.j_eq_ns    = (w_jv == w_ns);
        w_start.meta.k1         = w_k1[IDX_W-1:0];
        w_start.meta.k2         = w_k2[IDX_W-1:0];
        w_start.meta.has_up     = (w_ic != '0);
        w_start.meta.has_dn     = (w_ic != w_nt - 9'd1);
    end

    assign w_div_vld[0] = i_in_valid && w_en;
    assign w_div[0]     = w_start;

    // Divider chain: phases and texture coordinates, one bit per cell
    for (genvar p = 0; p < DIV_STEPS; p++) begin : g_div
        usmg_div_cell #(.POS(p)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ns    (w_ns),
            .i_nt    (w_nt),
            .i_vld   (w_div_vld[p]),
            .i_state (w_div[p]),
            .o_vld   (w_div_vld[p+1]),
            .o_state (w_div[p+1])
        );
    end

    // Trigonometry of both angles
    assign w_ph_st = {w_div[DIV_STEPS].meta.i_eq_nt,
                      w_div[DIV_STEPS].quo[LANE_PH_ST][30:0]};

    usmg_sincos u_se (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_div[DIV_STEPS].quo[LANE_PH_SE]),
        .o_cos   (w_se_cos),
        .o_sin   (w_se_sin)
    );

    usmg_sincos u_st (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_st),
        .o_cos   (w_st_cos),
        .o_sin   (w_st_sin)
    );

    // Side data beside the trigonometry
    always_comb begin
        w_post_in.func   = w_div[DIV_STEPS].meta.func;
        w_post_in.tex_s  = {w_div[DIV_STEPS].meta.j_eq_ns,
                            w_div[DIV_STEPS].quo[LANE_TEX_S][14:0]};
        w_post_in.tex_t  = {w_div[DIV_STEPS].meta.i_eq_nt,
                            w_div[DIV_STEPS].quo[LANE_TEX_T][14:0]};
        w_post_in.k1     = w_div[DIV_STEPS].meta.k1;
        w_post_in.k2     = w_div[DIV_STEPS].meta.k2;
        w_post_in.has_up = w_div[DIV_STEPS].meta.has_up;
        w_post_in.has_dn = w_div[DIV_STEPS].meta.has_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < POST_LAT; n++) begin
                r_post_vld[n] <= 1'b0;
            end
        end else if (w_en) begin
            r_post_vld[0] <= w_div_vld[DIV_STEPS];
            for (int n = 1; n < POST_LAT; n++) begin
                r_post_vld[n] <= r_post_vld[n-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_post[0] <= w_post_in;
            for (int n = 1; n < POST_LAT; n++) begin
                r_post[n] <= r_post[n-1];
            end
        end
    end

    // Products of the spherical coordinates, in sign and magnitude
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_px_mag <= 62'(f_mag(w_st_sin)) * 62'(f_mag(w_se_cos));
            r_m_px_neg <= w_st_sin[31] ^ w_se_cos[31];
            r_m_py_mag <= 62'(f_mag(w_st_sin)) * 62'(f_mag(w_se_sin));
            r_m_py_neg <= w_st_sin[31] ^ w_se_sin[31];
            r_m_z_mag  <= f_mag(w_st_cos);
            r_m_z_neg  <= w_st_cos[31];
        end
    end

    // Results of the item leaving the product stage
    always_comb begin
        w_vtx             = '0;
        w_vtx.pos_x       = f_rnd(r_m_px_mag, r_m_px_neg, 47);
        w_vtx.pos_y       = f_rnd(r_m_py_mag, r_m_py_neg, 47);
        w_vtx.pos_z       = f_rnd(62'(r_m_z_mag), r_m_z_neg, 17);
        w_vtx.norm_x      = f_rnd(r_m_px_mag, r_m_px_neg, 46);
        w_vtx.norm_y      = f_rnd(r_m_py_mag, r_m_py_neg, 46);
        w_vtx.norm_z      = f_rnd(62'(r_m_z_mag), r_m_z_neg, 16);
        w_vtx.tex_s       = r_post[POST_LAT-1].tex_s;
        w_vtx.tex_t       = r_post[POST_LAT-1].tex_t;
        w_vtx.last_of_run = 1'b1;

        w_tri_a            = '0;
        w_tri_a.tri_first  = r_post[POST_LAT-1].k1;
        w_tri_a.tri_second = r_post[POST_LAT-1].k2;
        w_tri_a.tri_third  = r_post[POST_LAT-1].k1 + 17'd1;

        w_tri_b             = '0;
        w_tri_b.tri_first   = r_post[POST_LAT-1].k1 + 17'd1;
        w_tri_b.tri_second  = r_post[POST_LAT-1].k2;
        w_tri_b.tri_third   = r_post[POST_LAT-1].k2 + 17'd1;
        w_tri_b.last_of_run = 1'b1;

        w_res1 = w_tri_b;
        w_two  = 1'b0;
        if (r_post[POST_LAT-1].func == FUNC_VERTEX) begin
            w_res0 = w_vtx;
        end else if (r_post[POST_LAT-1].has_up && r_post[POST_LAT-1].has_dn) begin
            w_res0 = w_tri_a;
            w_two  = 1'b1;
        end else if (r_post[POST_LAT-1].has_up) begin
            w_res0             = w_tri_a;
            w_res0.last_of_run = 1'b1;
        end else begin
            w_res0 = w_tri_b;
        end
    end

    // Output buffer: one item's results, shown one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_ob_sel <= 1'b0;
            r_ob_two <= 1'b0;
        end else if (w_en) begin
            r_ob_vld <= r_post_vld[POST_LAT-1];
            r_ob_sel <= 1'b0;
            r_ob_two <= w_two;
        end else if (i_out_ready) begin
            r_ob_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ob_res0 <= w_res0;
            r_ob_res1 <= w_res1;
        end
    end

    assign o_out_valid = r_ob_vld;
    assign o_out_item  = r_ob_sel ? r_ob_res1 : r_ob_res0;

endmodule
